// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the parse stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSP_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/pps_pkg.sv =====
// Types and constants of the precedence parse stack.
`timescale 1ns / 1ps
package pps_pkg;
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned MAX_POP = 8;
  localparam int unsigned SPAN    = MAX_POP + 1;

  typedef enum logic [1:0] {
    K_TOKEN  = 2'd0,
    K_EXP    = 2'd1,
    K_HANDLE = 2'd2,
    K_END    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    M_PUSH   = 3'd0,
    M_ADDH   = 3'd1,
    M_REDUCE = 3'd2,
    M_TOP    = 3'd3,
    M_FINAL  = 3'd4,
    M_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SYN = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_INSERT
  } cell_op_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  tok;
    logic [15:0] item_ref;
  } entry_t;

  // Running result of the topmost-token search down the chain
  typedef struct packed {
    logic       mark;
    kind_e      kind;
    logic [5:0] tok;
  } link_t;
endpackage

// ===== rtl/pps_if.sv =====
// Handshake interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [1:0]  entry_kind;
  logic [5:0]  token_kind;
  logic [15:0] item_ref;
  modport source (output valid, mode, entry_kind, token_kind, item_ref, input ready);
  modport sink (input valid, mode, entry_kind, token_kind, item_ref, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  out_kind;
  logic [5:0]  out_token_kind;
  logic [15:0] out_ref;
  logic        hit_end;
  logic        is_empty;
  logic [3:0]  moved_count;
  logic        final_item;
  modport source (output valid, status, out_kind, out_token_kind, out_ref, hit_end,
                  is_empty, moved_count, final_item, input ready);
  modport sink (input valid, status, out_kind, out_token_kind, out_ref, hit_end,
                is_empty, moved_count, final_item, output ready);
endinterface

// ===== rtl/pps_cell.sv =====
// One stack cell: holds an entry and passes the token search to the cell below.
`timescale 1ns / 1ps
module pps_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pps_pkg::cell_op_e op_i,
  input  logic             valid_i,
  input  pps_pkg::entry_t  above_i,
  input  pps_pkg::entry_t  below_i,
  input  pps_pkg::link_t   link_i,
  output pps_pkg::entry_t  entry_o,
  output pps_pkg::link_t   link_o
);
  import pps_pkg::*;

  entry_t entry_q, entry_d;
  link_t  link_q, link_d;
  logic   stop;

  // Token or end marker held here
  assign stop = valid_i && (entry_q.kind == K_TOKEN || entry_q.kind == K_END);

  // Select the next entry
  always_comb begin
    entry_d = entry_q;
    case (op_i)
      OP_PUSH:   entry_d = above_i;
      OP_POP:    entry_d = below_i;
      OP_INSERT: begin
        if (link_i.mark) begin
          entry_d = above_i;
        end else if (stop) begin
          entry_d = '{kind: K_HANDLE, tok: '0, item_ref: '0};
        end
      end
      default:   entry_d = entry_q;
    endcase
  end

  // Advance the search one cell per cycle
  always_comb begin
    if (link_i.mark) begin
      link_d = link_i;
    end else begin
      link_d = '{mark: stop, kind: entry_q.kind, tok: entry_q.tok};
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '{mark: 1'b0, kind: K_TOKEN, tok: '0};
    end else begin
      link_q <= link_d;
    end
  end

  assign entry_o = entry_q;
  assign link_o  = link_q;
endmodule

// ===== rtl/precedence_parse_stack.sv =====
// Push, clear and final-result query: executed in S_EXEC, result then registered.
// Top-token query and handle insertion wait until the cell chain has settled
// after the last stack change (the search moves one cell per cycle).
// Reduce: one result per cycle unless the output stalls, then S_DROP drops the handle.
// One item at a time. Reset empties the stack and sets max_reduce to 3.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module precedence_parse_stack (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  pps_in_if.sink     req_i,
  pps_out_if.source  rsp_o
);
  import pps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_EMIT, S_DROP} state_e;

  state_e            state_q;
  mode_e             mode_q;
  entry_t            new_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] settle_q;
  logic [3:0]        maxr_q, rem_q, cnt_q;
  logic              out_vq;
  logic [1:0]        o_status, o_kind;
  logic [5:0]        o_tok;
  logic [15:0]       o_ref;
  logic              o_end, o_empty, o_fin;
  logic [3:0]        o_cnt;

  entry_t   entries [DEPTH];
  link_t    links [DEPTH];
  cell_op_e op;
  entry_t   above0;

  logic       can_put, settled, full, load, chg;
  logic [3:0] lim, h_pos;
  logic       h_found;
  state_e     state_d;
  logic [3:0] rem_d, cnt_d;
  logic [1:0] r_status, r_kind;
  logic [5:0] r_tok;
  logic [15:0] r_ref;
  logic       r_end, r_empty, r_fin;
  logic [3:0] r_cnt;

  // Row of cells, top of stack in cell zero
  assign above0 = (op == OP_INSERT) ? '{kind: K_HANDLE, tok: '0, item_ref: '0} : new_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t above, below;
    link_t  lin;
    logic   vld;
    if (g == 0) begin : g_top
      assign above = above0;
      assign lin   = '{mark: 1'b0, kind: K_TOKEN, tok: '0};
    end else begin : g_mid
      assign above = entries[g-1];
      assign lin   = links[g-1];
    end
    if (g == DEPTH - 1) begin : g_bot
      assign below = '{kind: K_TOKEN, tok: '0, item_ref: '0};
    end else begin : g_nbot
      assign below = entries[g+1];
    end
    assign vld = FILL_W'(g) < fill_q;
    pps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .valid_i (vld),
      .above_i (above),
      .below_i (below),
      .link_i  (lin),
      .entry_o (entries[g]),
      .link_o  (links[g])
    );
  end

  assign can_put = !out_vq || rsp_o.ready;
  assign settled = settle_q == FILL_W'(DEPTH);
  assign full    = fill_q == FILL_W'(DEPTH);
  assign lim     = (maxr_q > 4'(MAX_POP)) ? 4'(MAX_POP) : maxr_q;

  // Find the topmost handle within reach of one reduce
  always_comb begin
    h_found = 1'b0;
    h_pos   = '0;
    for (int j = 0; j < SPAN && j < DEPTH; j++) begin
      if (!h_found && 4'(j) <= lim && FILL_W'(j) < fill_q &&
          entries[j].kind == K_HANDLE) begin
        h_found = 1'b1;
        h_pos   = 4'(j);
      end
    end
  end

  // Sequence one item
  always_comb begin
    state_d  = state_q;
    op       = OP_HOLD;
    fill_d   = fill_q;
    load     = 1'b0;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    r_status = ST_OK;
    r_kind   = '0;
    r_tok    = '0;
    r_ref    = '0;
    r_end    = 1'b0;
    r_empty  = 1'b0;
    r_cnt    = '0;
    r_fin    = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_put && (settled || !(mode_q == M_ADDH || mode_q == M_TOP))) begin
          load    = 1'b1;
          state_d = S_IDLE;
          case (mode_q)
            M_PUSH: begin
              if (full) begin
                r_status = ST_OVF;
              end else begin
                op     = OP_PUSH;
                fill_d = fill_q + 1'b1;
              end
            end
            M_ADDH: begin
              if (full) begin
                r_status = ST_OVF;
              end else if (!links[DEPTH-1].mark) begin
                r_status = ST_SYN;
              end else begin
                op     = OP_INSERT;
                fill_d = fill_q + 1'b1;
              end
            end
            M_REDUCE: begin
              if (!h_found) begin
                r_status = ST_SYN;
              end else if (h_pos == '0) begin
                op     = OP_POP;
                fill_d = fill_q - 1'b1;
              end else begin
                load    = 1'b0;
                rem_d   = h_pos;
                cnt_d   = h_pos;
                state_d = S_EMIT;
              end
            end
            M_TOP: begin
              if (!links[DEPTH-1].mark || links[DEPTH-1].kind == K_END) begin
                r_end = 1'b1;
              end else begin
                r_tok = links[DEPTH-1].tok;
              end
            end
            M_FINAL: begin
              r_empty = fill_q == FILL_W'(2) && entries[0].kind == K_EXP &&
                        entries[1].kind == K_END;
              if (fill_q != FILL_W'(2) || entries[0].kind != K_EXP) begin
                r_status = ST_SYN;
              end else begin
                r_kind = K_EXP;
                r_ref  = entries[0].item_ref;
              end
            end
            M_CLEAR: fill_d = '0;
            default: r_status = ST_OK;
          endcase
        end
      end
      S_EMIT: begin
        if (can_put) begin
          load   = 1'b1;
          r_kind = entries[0].kind;
          r_tok  = entries[0].tok;
          r_ref  = entries[0].item_ref;
          r_cnt  = cnt_q;
          r_fin  = rem_q == 4'd1;
          op     = OP_POP;
          fill_d = fill_q - 1'b1;
          rem_d  = rem_q - 1'b1;
          if (rem_q == 4'd1) begin
            state_d = S_DROP;
          end
        end
      end
      S_DROP: begin
        op      = OP_POP;
        fill_d  = fill_q - 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign chg = (op != OP_HOLD) || (fill_d != fill_q);

  // Hold state, item, level and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_PUSH;
      fill_q   <= '0;
      settle_q <= '0;
      maxr_q   <= 4'd3;
      rem_q    <= '0;
      cnt_q    <= '0;
      out_vq   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        maxr_q <= cfg_wdata_i;
      end
      if (chg) begin
        settle_q <= '0;
      end else if (!settled) begin
        settle_q <= settle_q + 1'b1;
      end
      if (state_q == S_IDLE && req_i.valid) begin
        mode_q <= mode_e'(req_i.mode);
      end
      if (load) begin
        out_vq <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  // Latch the pushed entry and the result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      case (kind_e'(req_i.entry_kind))
        K_TOKEN: new_q <= '{kind: K_TOKEN, tok: req_i.token_kind, item_ref: req_i.item_ref};
        K_EXP:   new_q <= '{kind: K_EXP, tok: '0, item_ref: req_i.item_ref};
        default: new_q <= '{kind: kind_e'(req_i.entry_kind), tok: '0, item_ref: '0};
      endcase
    end
    if (load) begin
      o_status <= r_status;
      o_kind   <= r_kind;
      o_tok    <= r_tok;
      o_ref    <= r_ref;
      o_end    <= r_end;
      o_empty  <= r_empty;
      o_cnt    <= r_cnt;
      o_fin    <= r_fin;
    end
  end

  assign req_i.ready          = state_q == S_IDLE;
  assign rsp_o.valid          = out_vq;
  assign rsp_o.status         = o_status;
  assign rsp_o.out_kind       = o_kind;
  assign rsp_o.out_token_kind = o_tok;
  assign rsp_o.out_ref        = o_ref;
  assign rsp_o.hit_end        = o_end;
  assign rsp_o.is_empty       = o_empty;
  assign rsp_o.moved_count    = o_cnt;
  assign rsp_o.final_item     = o_fin;

  `PSP_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > FILL_W'(DEPTH), "fill level above depth")
  `PSP_ASSERT(a_accept_exec, clk_i, rst_ni, req_i.valid && req_i.ready |=> state_q == S_EXEC, "accepted item not executed")
  `PSP_NEVER(a_emit_rem, clk_i, rst_ni, state_q == S_EMIT && rem_q == '0, "reduce emit with nothing left")
endmodule

// ===== bench/precedence_parse_stack_tb.sv =====
// Precedence parse stack testbench: directed and random traffic checked by a scoreboard.
`timescale 1ns / 1ps
module precedence_parse_stack_tb;
  import pps_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [5:0]  tok;
    logic [15:0] item_ref;
    logic        hit_end;
    logic        is_empty;
    logic [3:0]  moved;
    logic        last;
  } result_t;

  // Shadow stack and expected-result queue
  class stack_scoreboard;
    entry_t  stack[DEPTH];
    int      fill;
    int      limit;
    result_t pending[$];
    int      errors;

    function new();
      fill = 0;
      limit = 3;
      errors = 0;
    endfunction

    function result_t blank();
      result_t r;
      r = '0;
      r.last = 1'b1;
      return r;
    endfunction

    // Predict results for one accepted request
    function void note_request(logic [2:0] mode, logic [1:0] ek, logic [5:0] tk,
                               logic [15:0] rf);
      result_t r;
      entry_t e;
      int pos, cnt, hpos, lim;
      bit found;
      r = blank();
      case (mode)
        M_PUSH: begin
          if (fill >= DEPTH) r.status = ST_OVF;
          else begin
            e.kind = kind_e'(ek);
            e.tok = (ek == K_TOKEN) ? tk : 6'd0;
            e.item_ref = (ek == K_TOKEN || ek == K_EXP) ? rf : 16'd0;
            stack[fill] = e;
            fill++;
          end
          pending.push_back(r);
        end
        M_ADDH: begin
          found = 0;
          pos = 0;
          if (fill >= DEPTH) r.status = ST_OVF;
          else begin
            for (int i = fill; i > 0; i--)
              if (stack[i-1].kind == K_TOKEN || stack[i-1].kind == K_END) begin
                found = 1;
                pos = i;
                break;
              end
            if (!found) r.status = ST_SYN;
            else begin
              for (int i = fill; i > pos; i--) stack[i] = stack[i-1];
              stack[pos] = '{kind: K_HANDLE, tok: 6'd0, item_ref: 16'd0};
              fill++;
            end
          end
          pending.push_back(r);
        end
        M_REDUCE: begin
          lim = (limit > MAX_POP) ? MAX_POP : limit;
          cnt = 0;
          found = 0;
          hpos = 0;
          for (int i = fill; i > 0; i--) begin
            if (stack[i-1].kind == K_HANDLE) begin
              found = 1;
              hpos = i - 1;
              break;
            end
            if (cnt == lim) break;
            cnt++;
          end
          if (!found) begin
            r.status = ST_SYN;
            pending.push_back(r);
          end else if (cnt == 0) begin
            fill = hpos;
            pending.push_back(r);
          end else begin
            for (int k = 0; k < cnt; k++) begin
              e = stack[fill-1-k];
              r = '0;
              r.kind = e.kind;
              r.tok = e.tok;
              r.item_ref = e.item_ref;
              r.moved = 4'(cnt);
              r.last = (k == cnt - 1);
              pending.push_back(r);
            end
            fill = hpos;
          end
        end
        M_TOP: begin
          r.hit_end = 1'b1;
          for (int i = fill; i > 0; i--) begin
            if (stack[i-1].kind == K_TOKEN) begin
              r.tok = stack[i-1].tok;
              r.hit_end = 1'b0;
              break;
            end
            if (stack[i-1].kind == K_END) break;
          end
          pending.push_back(r);
        end
        M_FINAL: begin
          r.is_empty = (fill == 2 && stack[0].kind == K_END && stack[1].kind == K_EXP);
          if (fill != 2 || stack[1].kind != K_EXP) r.status = ST_SYN;
          else begin
            r.kind = K_EXP;
            r.item_ref = stack[1].item_ref;
          end
          pending.push_back(r);
        end
        M_CLEAR: begin
          fill = 0;
          pending.push_back(r);
        end
        default: pending.push_back(r);
      endcase
    endfunction

    // Compare one transferred result with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status); errors++;
      end
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.tok !== want.tok) begin
        $error("out_token_kind: expected %0d, got %0d", want.tok, got.tok); errors++;
      end
      if (got.item_ref !== want.item_ref) begin
        $error("out_ref: expected %h, got %h", want.item_ref, got.item_ref); errors++;
      end
      if (got.hit_end !== want.hit_end) begin
        $error("hit_end: expected %0d, got %0d", want.hit_end, got.hit_end); errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty); errors++;
      end
      if (got.moved !== want.moved) begin
        $error("moved_count: expected %0d, got %0d", want.moved, got.moved); errors++;
      end
      if (got.last !== want.last) begin
        $error("final_item: expected %0d, got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  pps_in_if   req ();
  pps_out_if  rsp ();

  stack_scoreboard sb;
  int  hold_off;
  bit  stall_on;
  int  txn_count;

  precedence_parse_stack DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req.sink),
    .rsp_o       (rsp.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Note transfers in both directions at the rising edge
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && req.valid && req.ready) begin
      sb.note_request(req.mode, req.entry_kind, req.token_kind, req.item_ref);
      txn_count++;
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.out_kind, rsp.out_token_kind, rsp.out_ref, rsp.hit_end,
              rsp.is_empty, rsp.moved_count, rsp.final_item};
      sb.check_result(got);
    end
  end

  // Receiver stall pattern, with an optional long hold-off
  initial begin
    int phase;
    phase = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off > 0) begin
        hold_off--;
        rsp.ready <= 1'b0;
      end else if (!stall_on) rsp.ready <= 1'b1;
      else rsp.ready <= ((phase % 7) < 4) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one item and hold it until transferred
  task automatic send_item(mode_e m, kind_e k, logic [5:0] t, logic [15:0] r);
    req.valid = 1'b1;
    req.mode = m;
    req.entry_kind = k;
    req.token_kind = t;
    req.item_ref = r;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  task automatic send_raw(logic [2:0] m);
    req.valid = 1'b1;
    req.mode = m;
    req.entry_kind = 2'($urandom);
    req.token_kind = 6'($urandom);
    req.item_ref = 16'($urandom);
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
  endtask

  // Random gap between bursts
  task automatic gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  // One well-formed expression: end marker, operands and operators, reduce chain
  task automatic expression_round();
    int n;
    send_item(M_CLEAR, K_TOKEN, 0, 0);
    send_item(M_PUSH, K_END, 0, 0);
    send_item(M_PUSH, K_EXP, 0, 16'($urandom));
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_item(M_PUSH, K_TOKEN, 6'($urandom), 16'($urandom));
      gap();
      send_item(M_TOP, K_TOKEN, 0, 0);
      send_item(M_ADDH, K_TOKEN, 0, 0);
      send_item(M_PUSH, K_EXP, 0, 16'($urandom));
    end
    repeat (n) begin
      send_item(M_REDUCE, K_TOKEN, 0, 0);
      send_item(M_PUSH, K_EXP, 0, 16'($urandom));
      gap();
    end
    send_item(M_FINAL, K_TOKEN, 0, 0);
  endtask

  initial begin
    automatic int limits[] = '{8, 1, 15, 0, 5};
    sb = new();
    hold_off = 0;
    stall_on = 0;
    txn_count = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 4'd0;
    req.valid = 1'b0;
    req.mode = 3'd0;
    req.entry_kind = 2'd0;
    req.token_kind = 6'd0;
    req.item_ref = 16'd0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty-stack errors, field extremes, unused modes
    send_item(M_REDUCE, K_TOKEN, 0, 0);
    send_item(M_ADDH, K_TOKEN, 0, 0);
    send_item(M_TOP, K_TOKEN, 0, 0);
    send_item(M_FINAL, K_TOKEN, 0, 0);
    send_raw(3'd6);
    send_raw(3'd7);
    send_item(M_PUSH, K_END, 6'h3f, 16'hffff);
    send_item(M_PUSH, K_TOKEN, 6'h3f, 16'hffff);
    send_item(M_PUSH, K_EXP, 6'h3f, 16'hffff);
    send_item(M_PUSH, K_HANDLE, 6'h2a, 16'h5555);
    send_item(M_REDUCE, K_TOKEN, 0, 0);
    send_item(M_TOP, K_TOKEN, 0, 0);
    send_item(M_ADDH, K_TOKEN, 0, 0);
    send_item(M_PUSH, K_TOKEN, 6'h00, 16'h0000);
    send_item(M_PUSH, K_EXP, 0, 16'haaaa);
    send_item(M_PUSH, K_EXP, 0, 16'h1234);
    send_item(M_REDUCE, K_TOKEN, 0, 0);
    send_item(M_REDUCE, K_TOKEN, 0, 0);
    send_item(M_CLEAR, K_TOKEN, 0, 0);
    send_item(M_PUSH, K_END, 0, 0);
    send_item(M_PUSH, K_EXP, 0, 16'hbeef);
    send_item(M_FINAL, K_TOKEN, 0, 0);

    // Fill to overflow while the receiver holds off
    hold_off = 150;
    repeat (DEPTH - 1) send_item(M_PUSH, K_TOKEN, 6'($urandom), 16'($urandom));
    send_item(M_PUSH, K_EXP, 0, 0);
    send_item(M_ADDH, K_TOKEN, 0, 0);
    send_item(M_CLEAR, K_TOKEN, 0, 0);
    drain();

    // Random phases over several limit settings
    stall_on = 1;
    expression_round();
    foreach (limits[i]) begin
      write_limit(4'(limits[i]));
      gap();
      if ($urandom_range(0, 2) == 0) send_raw(3'($urandom_range(0, 7)));
      else send_item(mode_e'($urandom_range(0, 2)), kind_e'($urandom),
                     6'($urandom), 16'($urandom));
      // Deep handle to hit the reduce limit
      send_item(M_PUSH, K_TOKEN, 6'($urandom), 0);
      send_item(M_ADDH, K_TOKEN, 0, 0);
      repeat ($urandom_range(0, 9)) send_item(M_PUSH, K_EXP, 0, 16'($urandom));
      send_item(M_REDUCE, K_TOKEN, 0, 0);
    end
    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_if.sv
rtl/pps_cell.sv
rtl/precedence_parse_stack.sv
bench/precedence_parse_stack_tb.sv
